// ----- design/bed_pkg.sv -----
// shared types and constants for the button event detector
// state codes, event codes, register indexes and the per-tick record type
// no dependencies
package bed_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned DebW   = 3;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgAw  = 2;
  localparam int unsigned CfgDw  = 16;

  localparam logic [TickW-1:0] ShortLimitRst = 16'd15;
  localparam logic [TickW-1:0] LongLimitRst  = 16'd50;
  localparam logic             ActiveLvlRst  = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_REPEAT   = 3'd3,
    ST_LONG     = 3'd4
  } state_t;

  typedef enum logic [CodeW-1:0] {
    EV_DOWN       = 3'd0,
    EV_UP         = 3'd1,
    EV_REPEAT     = 3'd2,
    EV_SINGLE     = 3'd3,
    EV_DOUBLE     = 3'd4,
    EV_LONG_START = 3'd5,
    EV_LONG_HOLD  = 3'd6
  } event_t;

  typedef enum logic [CfgAw-1:0] {
    REG_ACTIVE_LEVEL = 2'd0,
    REG_SHORT_LIMIT  = 2'd1,
    REG_LONG_LIMIT   = 2'd2
  } reg_idx_t;

  // events caused by one tick
  typedef struct packed {
    logic              two;
    event_t            code0;
    event_t            code1;
    logic [CntW-1:0]   cnt;
  } tick_rec_t;

  typedef struct packed {
    logic      valid;
    tick_rec_t rec;
  } rec_push_t;

endpackage

// ----- design/bed_front.sv -----
// front part: configuration registers, debouncer and click state machine
// turns each accepted tick into at most one queue record of up to two events
// depends on bed_pkg
module bed_front #(
  parameter int unsigned DEBOUNCE   = 3,
  parameter int unsigned REPEAT_MAX = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bed_pkg::CfgAw-1:0]  cfg_addr,
  input  logic [bed_pkg::CfgDw-1:0]  cfg_wdata,
  input  logic                       tick_acc,
  input  logic                       raw_level,
  output bed_pkg::rec_push_t         push
);
  import bed_pkg::*;

  state_t            state_r, state_nxt;
  logic [TickW-1:0]  tick_r, tick_nxt;
  logic [DebW-1:0]   deb_r, deb_nxt;
  logic              stable_r, stable_nxt;
  logic [CntW-1:0]   press_r, press_nxt;
  logic              active_r, active_nxt;
  logic [TickW-1:0]  short_r, short_nxt;
  logic [TickW-1:0]  long_r, long_nxt;

  logic [TickW-1:0]  tick_inc;
  logic [DebW-1:0]   deb_inc;
  logic              stable_new;
  logic              act;

  // tick count and debounce as seen by the state machine on this tick
  always_comb begin
    tick_inc = tick_r;
    if (state_r != ST_IDLE && tick_r != {TickW{1'b1}}) begin
      tick_inc = tick_r + 1'b1;
    end
    deb_inc    = deb_r + 1'b1;
    stable_new = stable_r;
    if (raw_level == stable_r) begin
      deb_inc = '0;
    end else if (deb_inc >= DebW'(DEBOUNCE)) begin
      stable_new = raw_level;
      deb_inc    = '0;
    end
    act = (stable_new == active_r);
  end

  always_comb begin
    state_nxt  = state_r;
    tick_nxt   = tick_r;
    deb_nxt    = deb_r;
    stable_nxt = stable_r;
    press_nxt  = press_r;
    active_nxt = active_r;
    short_nxt  = short_r;
    long_nxt   = long_r;
    push.valid     = 1'b0;
    push.rec.two   = 1'b0;
    push.rec.code0 = EV_DOWN;
    push.rec.code1 = EV_REPEAT;
    push.rec.cnt   = press_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE_LEVEL: begin
          active_nxt = cfg_wdata[0];
          stable_nxt = ~cfg_wdata[0];
          deb_nxt    = '0;
        end
        REG_SHORT_LIMIT: short_nxt = cfg_wdata;
        REG_LONG_LIMIT:  long_nxt  = cfg_wdata;
        default: ;
      endcase
    end else if (tick_acc) begin
      tick_nxt   = tick_inc;
      deb_nxt    = deb_inc;
      stable_nxt = stable_new;
      unique case (state_r)
        ST_IDLE: begin
          if (act) begin
            tick_nxt   = '0;
            press_nxt  = CntW'(1);
            push.valid = 1'b1;
            push.rec.code0 = EV_DOWN;
            state_nxt  = ST_PRESSED;
          end
        end
        ST_PRESSED: begin
          if (!act) begin
            push.valid = 1'b1;
            push.rec.code0 = EV_UP;
            tick_nxt   = '0;
            state_nxt  = ST_RELEASED;
          end else if (tick_inc > long_r) begin
            push.valid = 1'b1;
            push.rec.code0 = EV_LONG_START;
            state_nxt  = ST_LONG;
          end
        end
        ST_RELEASED: begin
          if (act) begin
            if (press_r < CntW'(REPEAT_MAX)) begin
              press_nxt = press_r + 1'b1;
            end
            push.valid = 1'b1;
            push.rec.two   = 1'b1;
            push.rec.code0 = EV_DOWN;
            push.rec.code1 = EV_REPEAT;
            tick_nxt   = '0;
            state_nxt  = ST_REPEAT;
          end else if (tick_inc > short_r) begin
            // three or more presses end silently
            if (press_r == CntW'(1)) begin
              push.valid = 1'b1;
              push.rec.code0 = EV_SINGLE;
            end else if (press_r == CntW'(2)) begin
              push.valid = 1'b1;
              push.rec.code0 = EV_DOUBLE;
            end
            state_nxt = ST_IDLE;
          end
        end
        ST_REPEAT: begin
          if (!act) begin
            push.valid = 1'b1;
            push.rec.code0 = EV_UP;
            if (tick_inc < short_r) begin
              tick_nxt  = '0;
              state_nxt = ST_RELEASED;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (tick_inc > short_r) begin
            state_nxt = ST_PRESSED;
          end
        end
        ST_LONG: begin
          push.valid = 1'b1;
          if (act) begin
            push.rec.code0 = EV_LONG_HOLD;
          end else begin
            push.rec.code0 = EV_UP;
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
      push.rec.cnt = press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tick_r   <= '0;
      deb_r    <= '0;
      stable_r <= ~ActiveLvlRst;
      press_r  <= '0;
      active_r <= ActiveLvlRst;
      short_r  <= ShortLimitRst;
      long_r   <= LongLimitRst;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      deb_r    <= deb_nxt;
      stable_r <= stable_nxt;
      press_r  <= press_nxt;
      active_r <= active_nxt;
      short_r  <= short_nxt;
      long_r   <= long_nxt;
    end
  end

endmodule

// ----- design/bed_queue.sv -----
// two-entry queue of tick records between the front and back parts
// depends on bed_pkg
module bed_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  bed_pkg::rec_push_t  push,
  input  logic                pop,
  output logic                full,
  output logic                q_valid,
  output bed_pkg::tick_rec_t  q_rec
);
  import bed_pkg::*;

  tick_rec_t   mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/bed_back.sv -----
// back part: output register that plays out the one or two events of a record
// depends on bed_pkg
module bed_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bed_pkg::tick_rec_t            q_rec,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bed_pkg::CodeW-1:0]     ev_code,
  output logic [bed_pkg::CntW-1:0]      ev_cnt,
  output logic                          ev_last
);
  import bed_pkg::*;

  logic       cur_valid_r, cur_valid_nxt;
  logic       second_r, second_nxt;
  tick_rec_t  cur_rec_r;
  logic       out_acc;

  assign out_acc    = cur_valid_r & out_tready;
  assign ev_last    = ~cur_rec_r.two | second_r;
  assign pop        = q_valid & (~cur_valid_r | (out_acc & ev_last));
  assign out_tvalid = cur_valid_r;
  assign ev_code    = second_r ? cur_rec_r.code1 : cur_rec_r.code0;
  assign ev_cnt     = cur_rec_r.cnt;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    second_nxt    = second_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      second_nxt    = 1'b0;
    end else if (out_acc) begin
      if (ev_last) begin
        cur_valid_nxt = 1'b0;
      end else begin
        second_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_rec_r <= q_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      second_r    <= second_nxt;
    end
  end

endmodule

// ----- design/button_event_detector_core.sv -----
// Push-button event detector. Each input item is one poll tick with the raw pin level; the
// block debounces it and emits press down, up, repeat, single click, double click, long
// start and long hold events. A tick is taken whenever the two-entry record queue has
// room, so ticks may arrive back to back. Most ticks give zero or one event; a new press
// after a release gives two (down, then repeat, the latter with tlast set), and the output
// register plays these out one per cycle while out_tready is high. Sustained rate is set
// by the output side: one event per cycle while out_tready is high.
// depends on bed_pkg, bed_front, bed_queue, bed_back
module button_event_detector_core #(
  parameter int unsigned DEBOUNCE   = 3,
  parameter int unsigned REPEAT_MAX = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bed_pkg::CfgAw-1:0]  cfg_addr,
  input  logic [bed_pkg::CfgDw-1:0]  cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [0] raw_level, [7:1] zero
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [7:0]                 out_tdata,  // [2:0] event_code, [6:3] repeat_count, [7] zero
  output logic                       out_tlast
);
  import bed_pkg::*;

  rec_push_t          push;
  tick_rec_t          q_rec;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  logic               tick_acc;
  logic [CodeW-1:0]   ev_code;
  logic [CntW-1:0]    ev_cnt;

  assign in_tready = ~q_full;
  assign tick_acc  = in_tvalid & in_tready;
  assign out_tdata = {1'b0, ev_cnt, ev_code};

  bed_front #(
    .DEBOUNCE   (DEBOUNCE),
    .REPEAT_MAX (REPEAT_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .tick_acc  (tick_acc),
    .raw_level (in_tdata[0]),
    .push      (push)
  );

  bed_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_rec   (q_rec)
  );

  bed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rec      (q_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ev_code    (ev_code),
    .ev_cnt     (ev_cnt),
    .ev_last    (out_tlast)
  );

endmodule
